/* hw/rtl/cpra_pkg.sv */
// Shared types and constants for the contiguous page run allocator.
// No dependencies; used by cpra_word_scan and contiguous_page_run_allocator_core.
package cpra_pkg;

    localparam int PAGE_SHIFT = 12;            // 4 KiB pages
    localparam int WORD_BITS  = 16;            // page marks per bitmap word
    localparam int WORD_LW    = 4;             // log2 of WORD_BITS
    localparam int NUM_W      = 21;            // page count of a 32-bit byte size
    localparam int REL_W      = 23;            // signed page offsets of a release
    localparam logic [32:0] PAGE_ROUND = 33'h0_0000_0fff;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REL_A,
        ST_REL_B,
        ST_REL_C,
        ST_SCAN,
        ST_ALLOC_HI,
        ST_SW_RD,
        ST_SW_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [WORD_LW-1:0] pos;
    } t_scan_hit;

endpackage

/* hw/rtl/cpra_word_scan.sv */
// Free-run evaluation of one bitmap word for the first-fit search.
// Depends on cpra_pkg.
module cpra_word_scan
    import cpra_pkg::*;
#(
    parameter int PW = 11
) (
    input  logic [WORD_BITS-1:0] i_used,
    input  logic [PW-1:0]        i_run_in,
    input  logic [PW-1:0]        i_num,
    output t_scan_hit            o_hit,
    output logic [PW-1:0]        o_run_out
);

    localparam int RW = PW + 1;

    logic [RW-1:0] run_j [WORD_BITS];

    // Run length ending at each bit: measured from the nearest used bit at or
    // below it, or continued from the previous words when the word is free below.
    always_comb begin : run_eval
        logic               found;
        logic [WORD_LW-1:0] last;
        for (int j = 0; j < WORD_BITS; j++) begin
            found = 1'b0;
            last  = '0;
            for (int k = 0; k <= j; k++) begin
                if (i_used[k]) begin
                    found = 1'b1;
                    last  = WORD_LW'(k);
                end
            end
            if (found) begin
                run_j[j] = RW'(WORD_LW'(j) - last);
            end else begin
                run_j[j] = {1'b0, i_run_in} + RW'(j + 1);
            end
        end
    end

    always_comb begin
        o_hit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!i_used[j] && (run_j[j] >= {1'b0, i_num})) begin
                o_hit.hit = 1'b1;
                o_hit.pos = WORD_LW'(j);
            end
        end
    end

    assign o_run_out = run_j[WORD_BITS-1][PW-1:0];

endmodule

/* hw/rtl/contiguous_page_run_allocator_core.sv */
// First-fit contiguous page allocator over a used-page bitmap of PAGES marks.
// Allocation scans the bitmap words in order, one 16-bit bitmap word read per cycle
// (WORDS = PAGES/16 rounded up); both ops then update each touched word by read and write.
// One request is worked on at a time; a finished response waits in an output register.
// Reset is synchronous, active low; it then clears the bitmap memory word by word,
// during which no request is taken. Depends on cpra_pkg and cpra_word_scan.
module contiguous_page_run_allocator_core
    import cpra_pkg::*;
#(
    parameter int PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: page_base byte address.
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] addr, [63:32] size
    input  logic        s_axis_tuser,   // [0] op: 0 allocate, 1 release
    // Response channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] address
    output logic        m_axis_tuser    // [0] ok
);

    // Bitmap geometry. Word indexes, page positions and counts are sized from PAGES.
    localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCW   = $clog2(WORDS + 1);
    localparam int PW    = $clog2(PAGES + 1);
    localparam int XW    = WIDX + WORD_LW;
    localparam int CW    = ((PW > XW) ? PW : XW) + 1;

    t_state r_state, n_state;

    // Bitmap memory: one used mark per page, 16 marks per word.
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    // Control decoded from the state.
    logic                 mem_we;
    logic [WIDX-1:0]      mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WIDX-1:0]      mem_raddr;
    logic                 scan_issue;
    logic                 out_load;

    // Request and working registers.
    logic [19:0]          r_base_pg;
    logic                 r_op;
    logic [19:0]          r_a0;
    logic [NUM_W-1:0]     r_num;
    logic [WIDX-1:0]      r_clr;
    logic [WCW-1:0]       r_ptr;
    logic                 r_ev_valid;
    logic [WIDX-1:0]      r_ev_word;
    logic [PW-1:0]        r_run;
    logic [PW-1:0]        r_lo;
    logic [PW-1:0]        r_hi;
    logic [REL_W-1:0]     r_d0;
    logic [REL_W-1:0]     r_d1;
    logic [WIDX-1:0]      r_sw_word;
    logic                 r_set;
    logic [31:0]          r_addr;
    logic                 r_ok;
    logic                 r_out_valid;
    logic [31:0]          r_out_addr;
    logic                 r_out_ok;

    // Combinational helpers.
    logic                 accept;
    logic [NUM_W-1:0]     num_in;
    logic                 num_bad;
    logic [WORD_BITS-1:0] used_ext;
    t_scan_hit            hit;
    logic [PW-1:0]        run_out;
    logic                 ev_last;
    logic [CW-1:0]        first_c;
    logic [PW-1:0]        lo_clamp;
    logic [PW-1:0]        hi_clamp;
    logic [WORD_BITS-1:0] sw_mask;
    logic                 sw_more;
    logic [WIDX-1:0]      lo_word;

    assign accept  = s_axis_tvalid && s_axis_tready;
    // Round the byte size up to pages without wrapping.
    assign num_in  = NUM_W'(({1'b0, s_axis_tdata[63:32]} + PAGE_ROUND) >> PAGE_SHIFT);
    assign num_bad = (num_in == '0) || (num_in > NUM_W'(PAGES));

    // Pages past the end of the managed range in the last word count as used,
    // so that no run can reach into them.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            used_ext[j] = r_rdata[j]
                        | (CW'({r_ev_word, WORD_LW'(j)}) >= CW'(PAGES));
        end
    end

    cpra_word_scan #(
        .PW (PW)
    ) u_scan (
        .i_used    (used_ext),
        .i_run_in  (r_run),
        .i_num     (r_num[PW-1:0]),
        .o_hit     (hit),
        .o_run_out (run_out)
    );

    assign ev_last = (r_ev_word == WIDX'(WORDS - 1));
    // Lowest page of the run that ends at the hit bit.
    assign first_c = CW'({r_ev_word, hit.pos}) + CW'(1) - CW'(r_num[PW-1:0]);

    // Release bounds relative to page_base, clamped to the managed pages.
    always_comb begin
        if (r_d0[REL_W-1]) begin
            lo_clamp = '0;
        end else if (r_d0 > REL_W'(PAGES)) begin
            lo_clamp = PW'(PAGES);
        end else begin
            lo_clamp = r_d0[PW-1:0];
        end
        if (r_d1[REL_W-1]) begin
            hi_clamp = '0;
        end else if (r_d1 > REL_W'(PAGES)) begin
            hi_clamp = PW'(PAGES);
        end else begin
            hi_clamp = r_d1[PW-1:0];
        end
    end

    // Mask of the pages in [lo, hi) that fall into the word being updated.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            sw_mask[j] = (CW'({r_sw_word, WORD_LW'(j)}) >= CW'(r_lo))
                      && (CW'({r_sw_word, WORD_LW'(j)}) <  CW'(r_hi));
        end
    end

    assign sw_more = (CW'({r_sw_word, WORD_LW'(0)}) + CW'(WORD_BITS)) < CW'(r_hi);
    assign lo_word = WIDX'(CW'(r_lo) >> WORD_LW);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == WIDX'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser) begin
                        n_state = ST_REL_A;
                    end else if (num_bad) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_REL_A: n_state = ST_REL_B;
            ST_REL_B: n_state = ST_REL_C;
            ST_REL_C: begin
                n_state = (hi_clamp > r_lo) ? ST_SW_RD : ST_DONE;
            end
            ST_SCAN: begin
                if (r_ev_valid) begin
                    if (hit.hit) begin
                        n_state = ST_ALLOC_HI;
                    end else if (ev_last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ALLOC_HI: n_state = ST_SW_RD;
            ST_SW_RD:    n_state = ST_SW_WR;
            ST_SW_WR: begin
                n_state = sw_more ? ST_SW_RD : ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_sw_word;
        mem_wdata     = r_set ? (r_rdata | sw_mask) : (r_rdata & ~sw_mask);
        mem_raddr     = r_sw_word;
        scan_issue    = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                mem_raddr  = r_ptr[WIDX-1:0];
                scan_issue = (r_ptr < WCW'(WORDS));
            end
            ST_SW_WR: begin
                mem_we = 1'b1;
            end
            ST_DONE: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Bitmap memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_base_pg   <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base_pg <= i_cfg_wdata[31:PAGE_SHIFT];
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + WIDX'(1);
            end
            if (r_state == ST_SCAN) begin
                r_ev_valid <= scan_issue;
            end else begin
                r_ev_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op   <= s_axis_tuser;
                r_a0   <= s_axis_tdata[31:PAGE_SHIFT];
                r_num  <= num_in;
                r_ptr  <= '0;
                r_run  <= '0;
                r_addr <= '0;
                r_ok   <= 1'b0;
            end
            ST_REL_A: begin
                r_d0 <= {3'b000, r_a0} - {3'b000, r_base_pg};
            end
            ST_REL_B: begin
                r_d1 <= r_d0 + {2'b00, r_num};
                r_lo <= lo_clamp;
            end
            ST_REL_C: begin
                r_hi      <= hi_clamp;
                r_set     <= 1'b0;
                r_ok      <= 1'b1;
                r_sw_word <= lo_word;
            end
            ST_SCAN: begin
                if (scan_issue) begin
                    r_ptr     <= r_ptr + WCW'(1);
                    r_ev_word <= r_ptr[WIDX-1:0];
                end
                if (r_ev_valid) begin
                    r_run <= run_out;
                    r_lo  <= first_c[PW-1:0];
                end
            end
            ST_ALLOC_HI: begin
                r_hi      <= r_lo + r_num[PW-1:0];
                r_addr    <= {r_base_pg, 12'h000} + (32'(r_lo) << PAGE_SHIFT);
                r_ok      <= 1'b1;
                r_set     <= 1'b1;
                r_sw_word <= lo_word;
            end
            ST_SW_WR: begin
                r_sw_word <= r_sw_word + WIDX'(1);
            end
            default: begin
                r_op <= r_op;
            end
        endcase
        if (out_load) begin
            r_out_addr <= r_op ? 32'h0000_0000 : r_addr;
            r_out_ok   <= r_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_ok;

endmodule
